// ----- sv/atrp_pkg.sv -----
package atrp_pkg;

  localparam int unsigned LINE_DEPTH_DEF = 64;

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;
  localparam logic [16:0] LEN_SAT         = 17'h10000;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam int unsigned HDR_LEN = 5;

  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_LINE     = 3'd1,
    KIND_ACCEPT   = 3'd2,
    KIND_BADDIGIT = 3'd3,
    KIND_TOOBIG   = 3'd4,
    KIND_OVERFLOW = 3'd5
  } kind_t;

  // what an incoming transaction will do, decided from current state
  typedef enum logic [2:0] {
    CLS_FLUSH,
    CLS_PAYLOAD,
    CLS_OVERFLOW,
    CLS_DUMP,
    CLS_NONE,
    CLS_STORE
  } cls_t;

  typedef struct packed {
    logic take;        // item accepted while idle
    logic dump_start;  // CR on a non-empty line
    logic rd_issue;    // read next line char from the store
    logic load_line;   // move read data to the output register
    logic load_last;
    logic line_clr;    // line run finished
  } ctrl_cmd_t;

  typedef struct packed {
    cls_t cls;
    logic out_free;
    logic rd_last;
  } dp_stat_t;

  // "+IPD,"
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h2B;
      3'd1:    ch = 8'h49;
      3'd2:    ch = 8'h50;
      3'd3:    ch = 8'h44;
      3'd4:    ch = 8'h2C;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- sv/atrp_ram.sv -----
module atrp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/atrp_ctrl.sv -----
module atrp_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  atrp_pkg::dp_stat_t       stat,
  output atrp_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

  state_t state_r, state_nxt;
  logic   dv_r, dv_nxt;          // store read data waiting at RAM output
  logic   dlast_r, dlast_nxt;    // that data is the final char of the run
  logic   issued_r, issued_nxt;  // final char already read

  always_comb begin
    state_nxt  = state_r;
    dv_nxt     = dv_r;
    dlast_nxt  = dlast_r;
    issued_nxt = issued_r;
    cmd        = '0;
    in_tready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = stat.out_free;
        if (in_tvalid && stat.out_free) begin
          cmd.take = 1'b1;
          if (stat.cls == atrp_pkg::CLS_DUMP) begin
            cmd.dump_start = 1'b1;
            state_nxt      = ST_DUMP;
            dv_nxt         = 1'b0;
            issued_nxt     = 1'b0;
          end
        end
      end
      ST_DUMP: begin
        if (dv_r && stat.out_free) begin
          cmd.load_line = 1'b1;
          cmd.load_last = dlast_r;
          dv_nxt        = 1'b0;
          if (dlast_r) begin
            cmd.line_clr = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
        if (!issued_r && (!dv_r || stat.out_free)) begin
          cmd.rd_issue = 1'b1;
          dv_nxt       = 1'b1;
          dlast_nxt    = stat.rd_last;
          issued_nxt   = stat.rd_last;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      dv_r     <= 1'b0;
      dlast_r  <= 1'b0;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      dv_r     <= dv_nxt;
      dlast_r  <= dlast_nxt;
      issued_r <= issued_nxt;
    end
  end

endmodule

// ----- sv/atrp_dp.sv -----
module atrp_dp #(
  parameter int unsigned LINE_DEPTH = atrp_pkg::LINE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     action,
  input  logic [7:0]               rx_byte,
  input  logic                     cfg_wr_en,
  input  logic [15:0]              cfg_wr_data,
  input  atrp_pkg::ctrl_cmd_t      cmd,
  output atrp_pkg::dp_stat_t       stat,
  input  logic                     out_tready,
  output logic                     out_valid,
  output logic [2:0]               out_kind,
  output logic [7:0]               out_data_byte,
  output logic [15:0]              out_length,
  output logic                     out_last
);

  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam logic [AW-1:0] LEN_FULL = AW'(LINE_DEPTH - 1);
  localparam logic [AW-1:0] LEN_HDR  = AW'(atrp_pkg::HDR_LEN);

  logic [15:0]   max_payload_r;
  logic [AW-1:0] line_len_r, line_len_nxt;
  logic [15:0]   pay_rem_r, pay_rem_nxt;
  logic          pref_ok_r, pref_ok_nxt;
  logic          bad_r, bad_nxt;
  logic [16:0]   acc_r, acc_nxt;
  logic [AW-1:0] rd_idx_r;
  logic          out_valid_r;
  atrp_pkg::kind_t out_kind_r;
  logic [7:0]    out_data_r;
  logic [15:0]   out_len_r;
  logic          out_last_r;

  atrp_pkg::cls_t cls;
  logic          is_digit;
  logic          hdr_hit;
  logic [20:0]   acc_mul;
  logic          store_we;
  logic [7:0]    rd_data;
  logic          res_load;
  atrp_pkg::kind_t res_kind;
  logic [7:0]    res_data;
  logic [15:0]   res_len;
  logic          res_last;

  always_comb begin
    if (action) begin
      cls = atrp_pkg::CLS_FLUSH;
    end else if (pay_rem_r != 16'd0) begin
      cls = atrp_pkg::CLS_PAYLOAD;
    end else if (line_len_r == LEN_FULL) begin
      cls = atrp_pkg::CLS_OVERFLOW;
    end else if (rx_byte == atrp_pkg::CH_CR) begin
      cls = (line_len_r == '0) ? atrp_pkg::CLS_NONE : atrp_pkg::CLS_DUMP;
    end else if (rx_byte == atrp_pkg::CH_LF) begin
      cls = atrp_pkg::CLS_NONE;
    end else begin
      cls = atrp_pkg::CLS_STORE;
    end
  end

  assign is_digit = rx_byte inside {[atrp_pkg::CH_ZERO:atrp_pkg::CH_NINE]};
  assign hdr_hit  = (line_len_r >= LEN_HDR) && pref_ok_r && (rx_byte == atrp_pkg::CH_COLON);
  // acc * 10 + digit
  assign acc_mul  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                  + {17'd0, rx_byte[3:0]};
  assign store_we = cmd.take && (cls == atrp_pkg::CLS_STORE);

  always_comb begin
    line_len_nxt = line_len_r;
    pay_rem_nxt  = pay_rem_r;
    pref_ok_nxt  = pref_ok_r;
    bad_nxt      = bad_r;
    acc_nxt      = acc_r;
    res_load     = 1'b0;
    res_kind     = atrp_pkg::KIND_PAYLOAD;
    res_data     = 8'd0;
    res_len      = 16'd0;
    res_last     = 1'b0;
    if (cmd.take) begin
      case (cls)
        atrp_pkg::CLS_FLUSH: pay_rem_nxt = 16'd0;
        atrp_pkg::CLS_PAYLOAD: begin
          pay_rem_nxt = pay_rem_r - 16'd1;
          res_load    = 1'b1;
          res_kind    = atrp_pkg::KIND_PAYLOAD;
          res_data    = rx_byte;
          res_last    = (pay_rem_r == 16'd1);
        end
        atrp_pkg::CLS_OVERFLOW: begin
          line_len_nxt = '0;
          res_load     = 1'b1;
          res_kind     = atrp_pkg::KIND_OVERFLOW;
        end
        atrp_pkg::CLS_STORE: begin
          line_len_nxt = line_len_r + AW'(1);
          if (line_len_r < LEN_HDR) begin
            pref_ok_nxt = ((line_len_r == '0) || pref_ok_r)
                        && (rx_byte == atrp_pkg::hdr_char(line_len_r[2:0]));
            bad_nxt     = 1'b0;
            acc_nxt     = 17'd0;
          end else if (hdr_hit) begin
            line_len_nxt = '0;
            res_load     = 1'b1;
            if (bad_r) begin
              res_kind = atrp_pkg::KIND_BADDIGIT;
            end else if (acc_r > {1'b0, max_payload_r}) begin
              res_kind = atrp_pkg::KIND_TOOBIG;
            end else begin
              res_kind    = atrp_pkg::KIND_ACCEPT;
              res_len     = acc_r[15:0];
              pay_rem_nxt = acc_r[15:0];
            end
          end else begin
            bad_nxt = bad_r || !is_digit;
            acc_nxt = (acc_mul > {4'd0, atrp_pkg::LEN_SAT}) ? atrp_pkg::LEN_SAT
                                                             : acc_mul[16:0];
          end
        end
        default: ;
      endcase
    end
    if (cmd.load_line) begin
      res_load = 1'b1;
      res_kind = atrp_pkg::KIND_LINE;
      res_data = rd_data;
      res_last = cmd.load_last;
    end
    if (cmd.line_clr) begin
      line_len_nxt = '0;
    end
  end

  atrp_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (line_len_r),
    .wdata (rx_byte),
    .re    (cmd.rd_issue),
    .raddr (rd_idx_r),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= atrp_pkg::MAX_PAYLOAD_RST;
      line_len_r    <= '0;
      pay_rem_r     <= 16'd0;
      pref_ok_r     <= 1'b0;
      bad_r         <= 1'b0;
      acc_r         <= 17'd0;
      rd_idx_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_payload_r <= cfg_wr_data;
      end
      line_len_r <= line_len_nxt;
      pay_rem_r  <= pay_rem_nxt;
      pref_ok_r  <= pref_ok_nxt;
      bad_r      <= bad_nxt;
      acc_r      <= acc_nxt;
      if (cmd.dump_start) begin
        rd_idx_r <= '0;
      end else if (cmd.rd_issue) begin
        rd_idx_r <= rd_idx_r + AW'(1);
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_kind_r <= res_kind;
      out_data_r <= res_data;
      out_len_r  <= res_len;
      out_last_r <= res_last;
    end
  end

  assign stat.cls      = cls;
  assign stat.out_free = !out_valid_r || out_tready;
  assign stat.rd_last  = (rd_idx_r == line_len_r - AW'(1));

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_data_byte = out_data_r;
  assign out_length    = out_len_r;
  assign out_last      = out_last_r;

endmodule

// ----- sv/at_response_line_and_payload_parser.sv -----
// A transaction with one result shows it in the output register in the cycle after accept.
// One transaction per cycle while the output register drains and no line is being dumped.
// A CR ending a line of L chars streams L results at one per cycle, while the output register
// drains, from the single line store read port; input waits until the last result is loaded.
// Reset (rst_n low, synchronous): empty line, no payload pending, max_payload = 1024;
// the line store contents are not cleared.
module at_response_line_and_payload_parser #(
  parameter int unsigned LINE_DEPTH = atrp_pkg::LINE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] rx_byte
  input  logic        in_tuser,     // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // [7:0] data_byte, [23:8] length
  output logic [2:0]  out_tuser,    // [2:0] kind
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  atrp_pkg::ctrl_cmd_t cmd;
  atrp_pkg::dp_stat_t  stat;
  logic [7:0]          out_data_byte;
  logic [15:0]         out_length;

  atrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  atrp_dp #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .action        (in_tuser),
    .rx_byte       (in_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .cmd           (cmd),
    .stat          (stat),
    .out_tready    (out_tready),
    .out_valid     (out_tvalid),
    .out_kind      (out_tuser),
    .out_data_byte (out_data_byte),
    .out_length    (out_length),
    .out_last      (out_tlast)
  );

  assign out_tdata = {out_length, out_data_byte};

endmodule

// ----- bench/tb_at_response_line_and_payload_parser.sv -----
`timescale 1ns / 1ps

module tb_at_response_line_and_payload_parser;

  localparam int unsigned LINE_DEPTH = atrp_pkg::LINE_DEPTH_DEF;

  typedef struct {
    logic       flush;
    logic [7:0] rx;
  } rx_item_t;

  typedef struct {
    atrp_pkg::kind_t kind;
    logic [7:0]      data;
    logic [15:0]     len;
    logic            eol;
  } parse_result_t;

  typedef enum int unsigned {
    FR_TEXT,
    FR_HDR,
    FR_BADDIG,
    FR_TOOBIG,
    FR_LONG,
    FR_NOISE,
    FR_BROKEN
  } frame_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;     // [7:0] rx_byte
  logic        in_tuser = 1'b0;   // [0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [7:0] data_byte, [23:8] length
  logic [2:0]  out_tuser;         // [2:0] kind
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  rx_item_t      rx_items_q[$];
  parse_result_t parser_results_q[$];

  // line/payload tracking state
  logic [7:0]  ln_buf [LINE_DEPTH];
  int unsigned ln_len = 0;
  logic [15:0] pay_left = '0;
  logic [15:0] max_pay = atrp_pkg::MAX_PAYLOAD_RST;

  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned n_errors = 0;
  int unsigned kind_seen [6] = '{default: 0};

  rx_item_t      in_cur;
  int unsigned   in_wait = 0;
  bit            in_fire = 1'b0;
  bit            in_calm = 1'b0;
  int unsigned   out_wait = 0;
  int unsigned   out_hold = 0;
  bit            out_fire = 1'b0;
  bit            out_calm = 1'b0;
  parse_result_t want;

  at_response_line_and_payload_parser #(.LINE_DEPTH(LINE_DEPTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned pick_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic void add_result(input atrp_pkg::kind_t k, input logic [7:0] d,
                                     input logic [15:0] l, input logic e);
    parse_result_t r;
    r.kind = k;
    r.data = d;
    r.len  = l;
    r.eol  = e;
    parser_results_q.push_back(r);
  endfunction

  function automatic void parse_rx(input rx_item_t it);
    int unsigned acc;
    int unsigned i;
    bit          bad;
    if (it.flush) begin
      pay_left = '0;
      return;
    end
    if (pay_left != 0) begin
      pay_left = pay_left - 1'b1;
      add_result(atrp_pkg::KIND_PAYLOAD, it.rx, '0, pay_left == 0);
    end else if (ln_len + 1 >= LINE_DEPTH) begin
      // byte dropped, line thrown away
      ln_len = 0;
      add_result(atrp_pkg::KIND_OVERFLOW, '0, '0, 1'b0);
    end else if (it.rx == atrp_pkg::CH_CR) begin
      for (i = 0; i < ln_len; i++)
        add_result(atrp_pkg::KIND_LINE, ln_buf[i], '0, i + 1 == ln_len);
      ln_len = 0;
    end else if (it.rx != atrp_pkg::CH_LF) begin
      ln_buf[ln_len] = it.rx;
      ln_len++;
      if (ln_len > atrp_pkg::HDR_LEN && it.rx == atrp_pkg::CH_COLON &&
          {ln_buf[0], ln_buf[1], ln_buf[2], ln_buf[3], ln_buf[4]} == "+IPD,") begin
        acc = 0;
        bad = 1'b0;
        for (i = atrp_pkg::HDR_LEN; i + 1 < ln_len; i++) begin
          if (ln_buf[i] < atrp_pkg::CH_ZERO || ln_buf[i] > atrp_pkg::CH_NINE) begin
            bad = 1'b1;
            break;
          end
          acc = acc * 10 + 32'(ln_buf[i] - atrp_pkg::CH_ZERO);
          if (acc > atrp_pkg::LEN_SAT) acc = 32'(atrp_pkg::LEN_SAT);
        end
        if (bad) begin
          add_result(atrp_pkg::KIND_BADDIGIT, '0, '0, 1'b0);
        end else if (acc > max_pay) begin
          add_result(atrp_pkg::KIND_TOOBIG, '0, '0, 1'b0);
        end else begin
          pay_left = acc[15:0];
          add_result(atrp_pkg::KIND_ACCEPT, '0, acc[15:0], 1'b0);
        end
        ln_len = 0;
      end
    end
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (in_wait != 0) begin
        in_wait--;
        in_tvalid <= 1'b0;
      end else if (rx_items_q.size() != 0) begin
        in_cur = rx_items_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= in_cur.rx;
        in_tuser <= in_cur.flush;
        in_wait = pick_gap(in_calm);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_fire = rst_n && in_tvalid && in_tready;
    if (in_fire) begin
      parse_rx(in_cur);
      items_taken++;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire) out_wait = pick_gap(out_calm);
      if (out_hold != 0) begin
        out_hold--;
        out_tready <= 1'b0;
      end else if (out_wait != 0) begin
        out_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_fire = rst_n && out_tvalid && out_tready;
    if (out_fire) begin
      if (out_tuser <= atrp_pkg::KIND_OVERFLOW) kind_seen[out_tuser]++;
      if (parser_results_q.size() == 0) begin
        $error("unexpected result transaction: kind %0d data %02h length %0d last %0b",
               out_tuser, out_tdata[7:0], out_tdata[23:8], out_tlast);
        n_errors++;
      end else begin
        want = parser_results_q.pop_front();
        if (out_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_tuser);
          n_errors++;
        end
        if (out_tdata[7:0] !== want.data) begin
          $error("data_byte: expected %02h, got %02h", want.data, out_tdata[7:0]);
          n_errors++;
        end
        if (out_tdata[23:8] !== want.len) begin
          $error("length: expected %0d, got %0d", want.len, out_tdata[23:8]);
          n_errors++;
        end
        if (out_tlast !== want.eol) begin
          $error("last: expected %0b, got %0b", want.eol, out_tlast);
          n_errors++;
        end
      end
    end
  end

  task automatic q_byte(input logic [7:0] b);
    rx_item_t it;
    it.flush = 1'b0;
    it.rx    = b;
    rx_items_q.push_back(it);
    items_queued++;
  endtask

  task automatic q_flush();
    rx_item_t it;
    it.flush = 1'b1;
    it.rx    = 8'($urandom_range(0, 255));
    rx_items_q.push_back(it);
    items_queued++;
  endtask

  task automatic q_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) q_byte(s[i]);
  endtask

  // wait for every transaction to go through, then let the block settle
  task automatic drain();
    while (items_taken != items_queued || parser_results_q.size() != 0) @(posedge clk);
    repeat (LINE_DEPTH + 8) @(posedge clk);
  endtask

  task automatic set_max(input logic [15:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    max_pay = v;
  endtask

  task automatic q_frame(input frame_t f);
    int unsigned n;
    int unsigned i;
    int unsigned pos;
    int unsigned len;
    int unsigned cut;
    logic [7:0]  b;
    string       s;
    case (f)
      FR_TEXT: begin
        n = $urandom_range(0, 14);
        for (i = 0; i < n; i++) q_byte(8'($urandom_range(0, 255)));
        q_byte(atrp_pkg::CH_CR);
        if ($urandom_range(0, 1)) q_byte(atrp_pkg::CH_LF);
      end
      FR_HDR: begin
        len = $urandom_range(0, (max_pay < 12) ? max_pay : 12);
        cut = (len != 0 && $urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : len + 1;
        s = $sformatf("%0d:", len);
        if ($urandom_range(0, 3) == 0) s = {"00", s};
        q_text({"+IPD,", s});
        for (i = 0; i < len; i++) begin
          if (i == cut) q_flush();
          q_byte(8'($urandom_range(0, 255)));
        end
        // leftover after an aborted payload lands in the line; close it
        if (cut <= len) q_byte(atrp_pkg::CH_CR);
      end
      FR_BADDIG: begin
        n = $urandom_range(0, 7);
        pos = $urandom_range(0, n);
        q_text("+IPD,");
        for (i = 0; i <= n; i++) begin
          if (i == pos) begin
            do b = 8'($urandom_range(0, 255));
            while ((b >= atrp_pkg::CH_ZERO && b <= atrp_pkg::CH_NINE) ||
                   b == atrp_pkg::CH_CR || b == atrp_pkg::CH_LF ||
                   b == atrp_pkg::CH_COLON);
            q_byte(b);
          end else begin
            q_byte(8'(atrp_pkg::CH_ZERO + $urandom_range(0, 9)));
          end
        end
        q_byte(atrp_pkg::CH_COLON);
      end
      FR_TOOBIG: begin
        q_text("+IPD,");
        if (max_pay != 16'hFFFF && $urandom_range(0, 2) != 0) begin
          q_text($sformatf("%0d", $urandom_range(65535, int'(max_pay) + 1)));
        end else begin
          // long digit strings saturate
          n = $urandom_range(6, 12);
          q_byte(8'(atrp_pkg::CH_ZERO + $urandom_range(1, 9)));
          for (i = 1; i < n; i++) q_byte(8'(atrp_pkg::CH_ZERO + $urandom_range(0, 9)));
        end
        q_byte(atrp_pkg::CH_COLON);
      end
      FR_LONG: begin
        n = $urandom_range(60, 68);
        for (i = 0; i < n; i++) q_byte(8'($urandom_range(8'h20, 8'h7E)));
        q_byte(atrp_pkg::CH_CR);
      end
      FR_NOISE: begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 3) == 0) q_flush();
          else q_byte(8'($urandom_range(0, 255)));
        end
      end
      default: begin
        s = "+IPD,12:";
        case ($urandom_range(0, 2))
          0:       q_text(s.substr(0, $urandom_range(0, 6)));
          1:       q_text("+IPX,3:");
          default: q_text(" +IPD,3:");
        endcase
        q_byte(atrp_pkg::CH_CR);
      end
    endcase
  endtask

  task automatic q_random_until(input int unsigned target, input bit first_long);
    int unsigned r;
    frame_t      f;
    if (first_long) q_frame(FR_LONG);
    while (items_queued < target) begin
      while (rx_items_q.size() > 8) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < 35) f = FR_HDR;
      else if (r < 60) f = FR_TEXT;
      else if (r < 70) f = FR_BADDIG;
      else if (r < 80) f = FR_TOOBIG;
      else if (r < 85) f = FR_LONG;
      else if (r < 93) f = FR_NOISE;
      else f = FR_BROKEN;
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      q_frame(f);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reset limit of 1024
    q_byte(8'h00);
    q_byte(8'hFF);
    q_byte(atrp_pkg::CH_LF);
    q_byte(atrp_pkg::CH_CR);
    q_byte(atrp_pkg::CH_CR);
    q_text("+IPD,:");
    q_text("+IPD,2:");
    q_byte(atrp_pkg::CH_CR);
    q_byte(atrp_pkg::CH_LF);
    q_text("+IPD,3:");
    q_byte(8'h41);
    q_flush();
    q_flush();
    drain();

    set_max(16'd0);
    q_text("+IPD,:");
    q_text("+IPD,1:");
    q_text("+IPD,00:");
    drain();

    set_max(16'hFFFF);
    q_text("+IPD,65535:");
    q_byte(atrp_pkg::CH_CR);
    q_byte(8'h80);
    q_byte(8'h7F);
    q_flush();
    q_text("+IPD,65536:");
    q_text("+IPD,99999999z:");
    drain();

    set_max(16'($urandom_range(1, 40)));
    q_random_until(230, 1'b1);
    drain();

    // output held off while lines keep coming in
    in_calm  = 1'b1;
    out_calm = 1'b0;
    out_hold = 400;
    repeat (4) q_frame(FR_TEXT);
    q_frame(FR_HDR);
    q_frame(FR_LONG);
    drain();

    set_max(16'($urandom_range(0, 65535)));
    q_random_until(330, 1'b0);
    drain();

    set_max(atrp_pkg::MAX_PAYLOAD_RST);
    q_random_until(430, 1'b0);
    drain();

    $display("Run: %0d input transactions, max_payload taken through 0, 65535 and others",
             items_taken);
    $display("Results: %0d payload, %0d line, %0d accepted,", kind_seen[0], kind_seen[1],
             kind_seen[2]);
    $display("         %0d bad digit, %0d too big, %0d overflow", kind_seen[3], kind_seen[4],
             kind_seen[5]);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("timeout: %0d of %0d transactions taken, %0d results outstanding",
             items_taken, items_queued, parser_results_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
